// ===== src/sdaf_pkg.sv =====
`timescale 1ns / 1ps

package sdaf_pkg;

   localparam int DATA_W          = 32;
   localparam int BCD_DIGITS      = 10;
   localparam int BCD_W           = 4 * BCD_DIGITS;
   localparam int STEP_W          = $clog2(DATA_W);
   localparam int MAX_FIELD_WIDTH = 15;
   localparam int CNT_W           = $clog2(MAX_FIELD_WIDTH + 1);
   localparam int CHAR_W          = 7;
   localparam int FIELD_WIDTH_W   = 4;
   localparam int PADDR_W         = 4;
   localparam int PDATA_W         = 32;
   localparam int REG_IDX_W       = 2;

   localparam logic [CHAR_W-1:0] ASCII_ZERO  = 7'd48;
   localparam logic [CHAR_W-1:0] ASCII_MINUS = 7'd45;
   localparam logic [CHAR_W-1:0] ASCII_SPACE = 7'd32;

   localparam logic [FIELD_WIDTH_W-1:0] FIELD_WIDTH_RESET = 4'd3;

   typedef enum logic [REG_IDX_W-1:0] {
      REG_FIELD_WIDTH = 2'd0,
      REG_SIGN_MODE   = 2'd1,
      REG_ZERO_PAD    = 2'd2
   } reg_idx_type;

   typedef struct packed {
      logic [FIELD_WIDTH_W-1:0] field_width;
      logic                     sign_mode;
      logic                     zero_pad;
   } cfg_type;

   typedef enum logic [2:0] {
      EMIT_IDLE,
      EMIT_NORM,
      EMIT_SIGN,
      EMIT_PAD,
      EMIT_DIGIT
   } emit_state_type;

endpackage

// ===== src/sdaf_csr.sv =====
`timescale 1ns / 1ps

module sdaf_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [sdaf_pkg::PADDR_W-1:0]     paddr,
   input  logic [sdaf_pkg::PDATA_W-1:0]     pwdata,
   output logic [sdaf_pkg::PDATA_W-1:0]     prdata,
   output logic                             pready,
   output sdaf_pkg::cfg_type                cfg
);

   sdaf_pkg::cfg_type                    cfg_ff;
   logic                                 wr_en;
   logic [sdaf_pkg::REG_IDX_W-1:0]       reg_idx;

   assign pready  = 1'b1;
   assign wr_en   = psel & penable & pwrite;
   assign reg_idx = paddr[sdaf_pkg::PADDR_W-1:2];
   assign cfg     = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.field_width <= sdaf_pkg::FIELD_WIDTH_RESET;
         cfg_ff.sign_mode   <= 1'b0;
         cfg_ff.zero_pad    <= 1'b1;
      end else if (wr_en) begin
         unique case (reg_idx)
            sdaf_pkg::REG_FIELD_WIDTH: begin
               cfg_ff.field_width <= pwdata[sdaf_pkg::FIELD_WIDTH_W-1:0];
            end
            sdaf_pkg::REG_SIGN_MODE: begin
               cfg_ff.sign_mode <= pwdata[0];
            end
            sdaf_pkg::REG_ZERO_PAD: begin
               cfg_ff.zero_pad <= pwdata[0];
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      prdata = '0;
      unique case (reg_idx)
         sdaf_pkg::REG_FIELD_WIDTH: begin
            prdata[sdaf_pkg::FIELD_WIDTH_W-1:0] = cfg_ff.field_width;
         end
         sdaf_pkg::REG_SIGN_MODE: begin
            prdata[0] = cfg_ff.sign_mode;
         end
         sdaf_pkg::REG_ZERO_PAD: begin
            prdata[0] = cfg_ff.zero_pad;
         end
         default: begin
            prdata = '0;
         end
      endcase
   end

endmodule

// ===== src/sdaf_dabble.sv =====
`timescale 1ns / 1ps

// Binary to BCD, one magnitude bit per cycle (shift and add 3).
module sdaf_dabble (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [sdaf_pkg::DATA_W-1:0]    mag,
   output logic                           done,
   output logic [sdaf_pkg::BCD_W-1:0]     bcd
);

   logic [sdaf_pkg::DATA_W-1:0]  bin_ff;
   logic [sdaf_pkg::BCD_W-1:0]   bcd_ff;
   logic [sdaf_pkg::BCD_W-1:0]   bcd_adj;
   logic [sdaf_pkg::STEP_W-1:0]  step_ff;
   logic                         run_ff;
   logic                         done_ff;

   always_comb begin
      for (int d = 0; d < sdaf_pkg::BCD_DIGITS; d++) begin
         if (bcd_ff[4*d +: 4] >= 4'd5) begin
            bcd_adj[4*d +: 4] = bcd_ff[4*d +: 4] + 4'd3;
         end else begin
            bcd_adj[4*d +: 4] = bcd_ff[4*d +: 4];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            run_ff  <= 1'b1;
            step_ff <= '0;
         end else if (run_ff) begin
            step_ff <= step_ff + 1'b1;
            if (step_ff == sdaf_pkg::STEP_W'(sdaf_pkg::DATA_W - 1)) begin
               run_ff  <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         bin_ff <= mag;
         bcd_ff <= '0;
      end else if (run_ff) begin
         bin_ff <= {bin_ff[sdaf_pkg::DATA_W-2:0], 1'b0};
         bcd_ff <= {bcd_adj[sdaf_pkg::BCD_W-2:0], bin_ff[sdaf_pkg::DATA_W-1]};
      end
   end

   assign done = done_ff;
   assign bcd  = bcd_ff;

endmodule

// ===== src/sdaf_emit.sv =====
`timescale 1ns / 1ps

// Drops leading zeros, then sends any sign, padding and digits, one beat a cycle unless stalled.
module sdaf_emit (
   input  logic                              clock,
   input  logic                              reset,
   input  sdaf_pkg::cfg_type                 cfg,
   input  logic                              start,
   input  logic                              negative,
   input  logic [sdaf_pkg::BCD_W-1:0]        bcd,
   input  logic                              rsp_ready,
   output logic                              rsp_valid,
   output logic [sdaf_pkg::CHAR_W-1:0]       rsp_character,
   output logic                              rsp_last
);

   sdaf_pkg::emit_state_type          state_ff;
   sdaf_pkg::emit_state_type          state_in;
   logic [sdaf_pkg::BCD_W-1:0]        digits_ff;
   logic [sdaf_pkg::CNT_W-1:0]        ndig_ff;
   logic [sdaf_pkg::CNT_W-1:0]        pad_ff;
   logic                              neg_ff;
   logic                              rsp_valid_ff;
   logic [sdaf_pkg::CHAR_W-1:0]       rsp_character_ff;
   logic                              rsp_last_ff;

   logic                              slot_free;
   logic                              top_zero;
   logic                              shift_lead;
   logic [sdaf_pkg::CNT_W-1:0]        width_eff;
   logic [sdaf_pkg::CNT_W-1:0]        pad_calc;
   logic [3:0]                        top_digit;
   logic                              beat_go;
   logic [sdaf_pkg::CHAR_W-1:0]       beat_char;
   logic                              beat_last;

   assign slot_free  = ~rsp_valid_ff | rsp_ready;
   assign top_digit  = digits_ff[sdaf_pkg::BCD_W-1 -: 4];
   assign top_zero   = (top_digit == 4'd0);
   assign shift_lead = top_zero && (ndig_ff > sdaf_pkg::CNT_W'(1));

   always_comb begin
      if (sdaf_pkg::CNT_W'(cfg.field_width) > sdaf_pkg::CNT_W'(sdaf_pkg::MAX_FIELD_WIDTH)) begin
         width_eff = sdaf_pkg::CNT_W'(sdaf_pkg::MAX_FIELD_WIDTH);
      end else begin
         width_eff = sdaf_pkg::CNT_W'(cfg.field_width);
      end
      if (width_eff > ndig_ff) begin
         pad_calc = width_eff - ndig_ff;
      end else begin
         pad_calc = '0;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         sdaf_pkg::EMIT_IDLE: begin
            if (start) begin
               state_in = sdaf_pkg::EMIT_NORM;
            end
         end
         sdaf_pkg::EMIT_NORM: begin
            if (!shift_lead) begin
               if (cfg.sign_mode) begin
                  state_in = sdaf_pkg::EMIT_SIGN;
               end else if (pad_calc != '0) begin
                  state_in = sdaf_pkg::EMIT_PAD;
               end else begin
                  state_in = sdaf_pkg::EMIT_DIGIT;
               end
            end
         end
         sdaf_pkg::EMIT_SIGN: begin
            if (slot_free) begin
               state_in = (pad_ff != '0) ? sdaf_pkg::EMIT_PAD : sdaf_pkg::EMIT_DIGIT;
            end
         end
         sdaf_pkg::EMIT_PAD: begin
            if (slot_free && pad_ff == sdaf_pkg::CNT_W'(1)) begin
               state_in = sdaf_pkg::EMIT_DIGIT;
            end
         end
         sdaf_pkg::EMIT_DIGIT: begin
            if (slot_free && ndig_ff == sdaf_pkg::CNT_W'(1)) begin
               state_in = sdaf_pkg::EMIT_IDLE;
            end
         end
         default: begin
            state_in = sdaf_pkg::EMIT_IDLE;
         end
      endcase
   end

   // beat produced this cycle
   always_comb begin
      beat_go   = 1'b0;
      beat_char = sdaf_pkg::ASCII_SPACE;
      beat_last = 1'b0;
      unique case (state_ff)
         sdaf_pkg::EMIT_SIGN: begin
            beat_go   = slot_free;
            beat_char = neg_ff ? sdaf_pkg::ASCII_MINUS : sdaf_pkg::ASCII_SPACE;
         end
         sdaf_pkg::EMIT_PAD: begin
            beat_go   = slot_free;
            beat_char = cfg.zero_pad ? sdaf_pkg::ASCII_ZERO : sdaf_pkg::ASCII_SPACE;
         end
         sdaf_pkg::EMIT_DIGIT: begin
            beat_go   = slot_free;
            beat_char = sdaf_pkg::ASCII_ZERO + {3'b000, top_digit};
            beat_last = (ndig_ff == sdaf_pkg::CNT_W'(1));
         end
         default: begin
            beat_go = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sdaf_pkg::EMIT_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (beat_go) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (beat_go) begin
         rsp_character_ff <= beat_char;
         rsp_last_ff      <= beat_last;
      end
      unique case (state_ff)
         sdaf_pkg::EMIT_IDLE: begin
            if (start) begin
               digits_ff <= bcd;
               ndig_ff   <= sdaf_pkg::CNT_W'(sdaf_pkg::BCD_DIGITS);
               neg_ff    <= negative;
            end
         end
         sdaf_pkg::EMIT_NORM: begin
            if (shift_lead) begin
               digits_ff <= {digits_ff[sdaf_pkg::BCD_W-5:0], 4'd0};
               ndig_ff   <= ndig_ff - 1'b1;
            end else begin
               pad_ff <= pad_calc;
            end
         end
         sdaf_pkg::EMIT_PAD: begin
            if (slot_free) begin
               pad_ff <= pad_ff - 1'b1;
            end
         end
         sdaf_pkg::EMIT_DIGIT: begin
            if (slot_free) begin
               digits_ff <= {digits_ff[sdaf_pkg::BCD_W-5:0], 4'd0};
               ndig_ff   <= ndig_ff - 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_character = rsp_character_ff;
   assign rsp_last      = rsp_last_ff;

endmodule

// ===== src/signed_decimal_ascii_formatter.sv =====
`timescale 1ns / 1ps
// A value passes the 32-step bit-serial BCD converter, then the leading-zero scan, which
//   drops z of the ten digits (at most nine), then the one-character-per-cycle output
//   stage, which sends n characters (up to 16) and is held by rsp_ready stalls. A new
//   number is accepted only after the final character of the last one has been taken.
// Reset (synchronous): field_width 3, sign_mode 0, zero_pad 1; block idle, no beat pending.
module signed_decimal_ascii_formatter (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic signed [sdaf_pkg::DATA_W-1:0] req_value,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [sdaf_pkg::CHAR_W-1:0]       rsp_character,
   output logic                              rsp_last,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [sdaf_pkg::PADDR_W-1:0]      paddr,
   input  logic [sdaf_pkg::PDATA_W-1:0]      pwdata,
   output logic [sdaf_pkg::PDATA_W-1:0]      prdata,
   output logic                              pready
);

   sdaf_pkg::cfg_type                cfg;
   logic                             busy_ff;
   logic                             neg_ff;
   logic                             req_fire;
   logic                             last_fire;
   logic [sdaf_pkg::DATA_W-1:0]      mag;
   logic                             conv_done;
   logic [sdaf_pkg::BCD_W-1:0]       conv_bcd;

   assign req_ready = ~busy_ff;
   assign req_fire  = req_valid & req_ready;
   assign last_fire = rsp_valid & rsp_ready & rsp_last;

   // most negative value wraps to 2^31, which is the right unsigned magnitude
   assign mag = req_value[sdaf_pkg::DATA_W-1] ? (sdaf_pkg::DATA_W'(0) - $unsigned(req_value))
                                              : $unsigned(req_value);

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else if (req_fire) begin
         busy_ff <= 1'b1;
      end else if (last_fire) begin
         busy_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         neg_ff <= req_value[sdaf_pkg::DATA_W-1];
      end
   end

   sdaf_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   sdaf_dabble u_dabble (
      .clock (clock),
      .reset (reset),
      .start (req_fire),
      .mag   (mag),
      .done  (conv_done),
      .bcd   (conv_bcd)
   );

   sdaf_emit u_emit (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg),
      .start         (conv_done),
      .negative      (neg_ff),
      .bcd           (conv_bcd),
      .rsp_ready     (rsp_ready),
      .rsp_valid     (rsp_valid),
      .rsp_character (rsp_character),
      .rsp_last      (rsp_last)
   );

   a_no_beat_when_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy_ff)
      else $error("result beat while no number in flight");

   a_ready_after_last: assert property (@(posedge clock) disable iff (reset)
      last_fire |=> req_ready)
      else $error("input not reopened after final character");

   a_last_is_digit: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_last) |->
         (rsp_character >= sdaf_pkg::ASCII_ZERO &&
          rsp_character <= sdaf_pkg::ASCII_ZERO + 7'd9))
      else $error("final character is not a digit");

   a_accept_closes_input: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> !req_ready)
      else $error("input accepted again while converting");

endmodule
